[rtl/ws2812_pkg.sv]
// constants and field widths shared by the ws2812 sequencer files
`default_nettype none
package ws2812_pkg;

	// field widths
	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int COLOR_W  = 8;
	localparam int WORD_W   = 16;
	localparam int LEDS_W   = 9;
	localparam int DUTY_W   = 15;
	localparam int PIXEL_W  = 3 * COLOR_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO = 2'd2;

	// register reset values
	localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 15'd13;
	localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 15'd7;

	// command codes
	localparam logic [ACTION_W-1:0] ACT_SET   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FILL  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_START = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd4;

	// padding word sent after the pixel data
	localparam logic [WORD_W-1:0] PAD_WORD = 16'h8000;

	// bit and byte positions inside one pixel
	localparam logic [2:0] LAST_BIT  = 3'd7;
	localparam logic [1:0] LAST_BYTE = 2'd2;

endpackage : ws2812_pkg
`default_nettype wire

[rtl/ws2812_cmd_if.sv]
// command channel: valid/ready with the command fields
`default_nettype none
interface ws2812_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [ws2812_pkg::ACTION_W-1:0]     action;
	logic [ws2812_pkg::INDEX_W-1:0]      index;
	logic [ws2812_pkg::COUNT_W-1:0]      count;
	logic [ws2812_pkg::COLOR_W-1:0]      red;
	logic [ws2812_pkg::COLOR_W-1:0]      green;
	logic [ws2812_pkg::COLOR_W-1:0]      blue;

	modport source (output valid, action, index, count, red, green, blue, input ready);
	modport sink   (input valid, action, index, count, red, green, blue, output ready);
endinterface : ws2812_cmd_if
`default_nettype wire

[rtl/ws2812_word_if.sv]
// duty word channel: valid/ready with the sequence word and last flag
`default_nettype none
interface ws2812_word_if;
	logic                              valid;
	logic                              ready;
	logic [ws2812_pkg::WORD_W-1:0]     sequence_word;
	logic                              last_word;

	modport source (output valid, sequence_word, last_word, input ready);
	modport sink   (input valid, sequence_word, last_word, output ready);
endinterface : ws2812_word_if
`default_nettype wire

[rtl/ws2812_pixel_pwm_sequencer.sv]
// ws2812 pixel store and pwm duty word sequencer, top level
//
// Commands arrive on the cmd channel (valid/ready), one beat per command:
// set pixel, fill range, clear, start playback, tick. Each tick taken while
// playing yields one beat on the seq channel: a duty word per pixel bit
// (green, red, blue, msb first), then two padding words, the second flagged
// last. Registers led_count, duty_one, duty_zero must be written through the
// cfg port (cfg_we, cfg_index, cfg_data) only while the block is idle; the
// block does not enforce this. Pixels live in a single-port memory of
// MAX_LEDS rows of 24 bits with a registered read, one row per cycle. Set,
// start, idle tick, unused code and rejected fill keep the block idle. A
// tick while playing passes the read state, which registers the pixel row,
// then the emit state, which loads the beat. Fill sweeps count rows from
// index, clear the leds in use. After reset a pass clears all MAX_LEDS rows,
// during which cmd.ready stays low; cfg writes are taken as usual.
// The beat waits in an output register while seq.ready is low; commands
// keep being taken, but the next tick holds in its emit cycle until the
// output register is free.
`default_nettype none
module ws2812_pixel_pwm_sequencer #(
	parameter int MAX_LEDS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ws2812_cmd_if.sink                             cmd,
	ws2812_word_if.source                          seq,
	input  wire logic                              cfg_we,
	input  wire logic [ws2812_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ws2812_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int PTR_W = $clog2(MAX_LEDS + 1);
	localparam int LW    = ws2812_pkg::LEDS_W;
	localparam int PW    = ws2812_pkg::PIXEL_W;
	localparam int CW    = ws2812_pkg::COLOR_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_FILL = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                     state_q;
	logic [LW-1:0]                  led_cnt_q;
	logic [ws2812_pkg::DUTY_W-1:0]  duty_one_q;
	logic [ws2812_pkg::DUTY_W-1:0]  duty_zero_q;
	logic                           playing_q;
	logic [LW-1:0]                  led_q;
	logic [1:0]                     byte_q;
	logic [2:0]                     bit_q;
	logic [PTR_W-1:0]               ptr_q;
	logic [PTR_W-1:0]               end_q;
	logic [PW-1:0]                  fill_q;
	logic [PW-1:0]                  rdata_q;
	logic                           out_valid_q;
	logic [ws2812_pkg::WORD_W-1:0]  out_word_q;
	logic                           out_last_q;

	logic [PW-1:0]                  mem [MAX_LEDS];

	logic [LW-1:0]                  n_leds;
	logic                           accept;
	logic [LW:0]                    fill_end;
	logic                           fill_ok;
	logic                           sweep_busy;
	logic                           mem_we;
	logic [AW-1:0]                  mem_wa;
	logic [PW-1:0]                  mem_wd;
	logic                           mem_re;
	logic                           in_data;
	logic                           at_end;
	logic                           emit_load;
	logic                           emit_last;
	logic [ws2812_pkg::WORD_W-1:0]  emit_word;
	logic [CW-1:0]                  sel_byte;
	logic [LW-1:0]                  led_nx;
	logic [1:0]                     byte_nx;
	logic [2:0]                     bit_nx;

	// leds in use, saturated at the store size
	always_comb begin
		if (32'(led_cnt_q) > MAX_LEDS) begin
			n_leds = LW'(MAX_LEDS);
		end else begin
			n_leds = led_cnt_q;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// fill range check
	assign fill_end = {1'b0, LW'(cmd.index)} + {1'b0, cmd.count};
	assign fill_ok  = (fill_end <= {1'b0, n_leds});

	// row sweep shared by reset pass, fill and clear
	assign sweep_busy = (state_q == ST_INIT || state_q == ST_FILL) && (ptr_q != end_q);

	// memory write port, the reset pass always writes zero
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q[AW-1:0];
		mem_wd = fill_q;
		if (sweep_busy) begin
			mem_we = 1'b1;
			if (state_q == ST_INIT) begin
				mem_wd = '0;
			end
		end else if (accept && cmd.action == ws2812_pkg::ACT_SET
				&& LW'(cmd.index) < n_leds) begin
			mem_we = 1'b1;
			mem_wa = AW'(cmd.index);
			mem_wd = {cmd.green, cmd.red, cmd.blue};
		end
	end

	assign mem_re = (state_q == ST_RD) && (led_q < n_leds);

	// pixel memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[AW'(led_q)];
		end
	end

	// position of the next word relative to the data end
	assign in_data = (led_q < n_leds);
	assign at_end  = (led_q == n_leds) && (byte_q == 2'd0) && (bit_q == 3'd0);

	// byte and bit selection of the current pixel
	always_comb begin
		case (byte_q)
			2'd0:    sel_byte = rdata_q[PW-1 -: CW];
			2'd1:    sel_byte = rdata_q[CW +: CW];
			default: sel_byte = rdata_q[CW-1:0];
		endcase
	end

	always_comb begin
		emit_last = 1'b0;
		if (in_data) begin
			emit_word = sel_byte[ws2812_pkg::LAST_BIT - bit_q] ?
				{1'b0, duty_one_q} : {1'b0, duty_zero_q};
		end else begin
			emit_word = ws2812_pkg::PAD_WORD;
			emit_last = !at_end;
		end
	end

	// position increment: bit, then byte, then led
	always_comb begin
		led_nx  = led_q;
		byte_nx = byte_q;
		bit_nx  = bit_q + 3'd1;
		if (bit_q == ws2812_pkg::LAST_BIT) begin
			if (byte_q == ws2812_pkg::LAST_BYTE) begin
				byte_nx = 2'd0;
				led_nx  = led_q + LW'(1);
			end else begin
				byte_nx = byte_q + 2'd1;
			end
		end
	end

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || seq.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_cnt_q   <= '0;
			duty_one_q  <= ws2812_pkg::DUTY_ONE_RST;
			duty_zero_q <= ws2812_pkg::DUTY_ZERO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ws2812_pkg::REG_LED_COUNT: led_cnt_q   <= cfg_data[LW-1:0];
				ws2812_pkg::REG_DUTY_ONE:  duty_one_q  <= cfg_data;
				ws2812_pkg::REG_DUTY_ZERO: duty_zero_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			ptr_q     <= '0;
			end_q     <= PTR_W'(MAX_LEDS);
			playing_q <= 1'b0;
			led_q     <= '0;
			byte_q    <= '0;
			bit_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							ws2812_pkg::ACT_FILL: begin
								if (fill_ok) begin
									ptr_q   <= PTR_W'(cmd.index);
									end_q   <= PTR_W'(fill_end);
									state_q <= ST_FILL;
								end
							end
							ws2812_pkg::ACT_CLEAR: begin
								ptr_q   <= '0;
								end_q   <= PTR_W'(n_leds);
								state_q <= ST_FILL;
							end
							ws2812_pkg::ACT_START: begin
								if (n_leds != '0) begin
									playing_q <= 1'b1;
									led_q     <= '0;
									byte_q    <= '0;
									bit_q     <= '0;
								end
							end
							ws2812_pkg::ACT_TICK: begin
								if (playing_q) begin
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INIT, ST_FILL: begin
					if (sweep_busy) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
						if (emit_last) begin
							playing_q <= 1'b0;
							led_q     <= '0;
							byte_q    <= '0;
							bit_q     <= '0;
						end else begin
							led_q  <= led_nx;
							byte_q <= byte_nx;
							bit_q  <= bit_nx;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill color, zero for clear
	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd.action == ws2812_pkg::ACT_CLEAR) begin
				fill_q <= '0;
			end else begin
				fill_q <= {cmd.green, cmd.red, cmd.blue};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (seq.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= emit_word;
			out_last_q <= emit_last;
		end
	end

	assign seq.valid         = out_valid_q;
	assign seq.sequence_word = out_word_q;
	assign seq.last_word     = out_last_q;

	// last flag only rides on a padding word
	a_last_is_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_word_q == ws2812_pkg::PAD_WORD))
		else $error("last beat without padding word");

	// no store write while a tick reads the store
	a_no_write_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_EMIT) |-> !mem_we)
		else $error("store written during tick");

	// playback stops after the last beat is loaded
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && emit_last) |=> !playing_q)
		else $error("playback still on after last beat");

	// row sweep never runs past its end
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_FILL) |-> (ptr_q <= end_q))
		else $error("row sweep past end");

	// a tick only enters the read stage while playing
	a_tick_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> playing_q)
		else $error("tick read without playback");

endmodule : ws2812_pixel_pwm_sequencer
`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the ws2812 pixel store and duty word sequencer
`timescale 1ns / 1ps
module tb_top;
	import ws2812_pkg::*;

	localparam int LED_LIMIT    = 256;
	localparam int STORE_BYTES  = LED_LIMIT * 3;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 200;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int IDLE_PCT     = 26;

	// command codes the block ignores, and a register index past the list
	localparam logic [ACTION_W-1:0]  ACT_SPARE_LO = 3'd5;
	localparam logic [ACTION_W-1:0]  ACT_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  index;
		logic [COUNT_W-1:0]  count;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
	} cmd_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] sequence_word;
		logic              last_word;
	} word_beat_t;

	// per command beat: a typed-in result overrides the prediction
	typedef struct packed {
		logic       typed;
		logic       typed_has;
		word_beat_t typed_res;
	} beat_note_t;

	typedef enum logic {ROW_CMD, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e             kind;
		cmd_beat_t             beat;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		int                    reps;
		beat_note_t            note;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ws2812_cmd_if  cmd_bus();
	ws2812_word_if seq_bus();

	ws2812_pixel_pwm_sequencer #(.MAX_LEDS(LED_LIMIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.seq       (seq_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block state and registers
	logic [COLOR_W-1:0] pixel_bytes [STORE_BYTES];
	logic               playing;
	logic [12:0]        word_pos;
	logic [LEDS_W-1:0]  leds_reg;
	logic [DUTY_W-1:0]  duty_one_reg;
	logic [DUTY_W-1:0]  duty_zero_reg;

	word_beat_t pending_words [$];
	beat_note_t beat_notes [$];
	plan_row_t  plan [$];

	int  errors;
	int  commands_sent;
	int  words_seen;
	int  reg_writes;
	int  stall_cycles;
	bit  calm;
	bit  dirty;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned active_leds();
		return (leds_reg > LED_LIMIT) ? LED_LIMIT : int'(leds_reg);
	endfunction

	function automatic void paint_pixel(input int unsigned n, input cmd_beat_t c);
		pixel_bytes[n * 3]     = c.green;
		pixel_bytes[n * 3 + 1] = c.red;
		pixel_bytes[n * 3 + 2] = c.blue;
	endfunction

	// next duty word and store update for one command beat
	function automatic void apply_command(input cmd_beat_t c, output bit produced,
			output word_beat_t res);
		int unsigned n;
		int unsigned data_words;
		int unsigned first;
		int unsigned span;
		logic [COLOR_W-1:0] cur;
		n = active_leds();
		data_words = n * 24;
		first = c.index;
		span = c.count;
		produced = 1'b0;
		res = '0;
		case (c.action)
			ACT_SET: begin
				if (first < n) paint_pixel(first, c);
			end
			ACT_FILL: begin
				if (first + span <= n)
					for (int unsigned i = first; i < first + span; i++) paint_pixel(i, c);
			end
			ACT_CLEAR: begin
				for (int unsigned i = 0; i < n * 3; i++) pixel_bytes[i] = '0;
			end
			ACT_START: begin
				if (n != 0) begin
					playing = 1'b1;
					word_pos = '0;
				end
			end
			ACT_TICK: begin
				if (playing) begin
					produced = 1'b1;
					if (word_pos < data_words) begin
						cur = pixel_bytes[word_pos >> 3];
						res.sequence_word = cur[LAST_BIT - word_pos[2:0]] ?
							{1'b0, duty_one_reg} : {1'b0, duty_zero_reg};
						word_pos = word_pos + 1'b1;
					end else if (word_pos == data_words) begin
						res.sequence_word = PAD_WORD;
						word_pos = word_pos + 1'b1;
					end else begin
						res.sequence_word = PAD_WORD;
						res.last_word = 1'b1;
						playing = 1'b0;
						word_pos = '0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		case (sel)
			REG_LED_COUNT: leds_reg = val[LEDS_W-1:0];
			REG_DUTY_ONE:  duty_one_reg = val[DUTY_W-1:0];
			REG_DUTY_ZERO: duty_zero_reg = val[DUTY_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic plan_row_t cmd_row(input logic [ACTION_W-1:0] action, input int index,
			input int count, input int red, input int green, input int blue, input int reps);
		plan_row_t r;
		r.kind = ROW_CMD;
		r.beat = '{action, INDEX_W'(index), COUNT_W'(count), COLOR_W'(red), COLOR_W'(green),
			COLOR_W'(blue)};
		r.reg_sel = '0;
		r.reg_val = '0;
		r.reps = reps;
		r.note = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [ACTION_W-1:0] action, input bit has,
			input logic [WORD_W-1:0] word, input bit last);
		plan_row_t r;
		r = cmd_row(action, 0, 0, 0, 0, 0, 1);
		r.note = '{1'b1, has, '{word, last}};
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] sel, input int val);
		plan_row_t r;
		r = cmd_row(ACT_SET, 0, 0, 0, 0, 0, 0);
		r.kind = ROW_REG;
		r.reg_sel = sel;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	// random store write, or any code at all when noise is asked for
	function automatic cmd_beat_t random_beat(input int unsigned n, input bit noise);
		cmd_beat_t b;
		int unsigned roll;
		int unsigned top;
		roll = $urandom_range(0, 99);
		b.action = noise ? ACTION_W'($urandom_range(0, 7)) :
			(roll < 50) ? ACT_SET : (roll < 85) ? ACT_FILL : ACT_CLEAR;
		b.index = INDEX_W'($urandom_range(0, 255));
		b.count = COUNT_W'($urandom_range(0, 511));
		b.red   = COLOR_W'($urandom_range(0, 255));
		b.green = COLOR_W'($urandom_range(0, 255));
		b.blue  = COLOR_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (b.action == ACT_SET && n != 0 && roll < 80)
			b.index = INDEX_W'($urandom_range(0, n - 1));
		if (b.action == ACT_FILL) begin
			if (roll < 10) begin
				b.count = '0;
			end else if (roll < 25) begin
				b.index = '0;
				b.count = COUNT_W'(n);
			end else if (roll >= 35 && n != 0) begin
				b.index = INDEX_W'($urandom_range(0, n - 1));
				top = n - b.index;
				if (top > 16) top = 16;
				b.count = COUNT_W'($urandom_range(1, top));
			end
		end
		return b;
	endfunction

	// offer one command beat and wait until it is taken
	task automatic send_command(input cmd_beat_t b, input beat_note_t note);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_bus.valid = 1'b0;
			@(negedge clk);
		end
		beat_notes.push_back(note);
		cmd_bus.valid  = 1'b1;
		cmd_bus.action = b.action;
		cmd_bus.index  = b.index;
		cmd_bus.count  = b.count;
		cmd_bus.red    = b.red;
		cmd_bus.green  = b.green;
		cmd_bus.blue   = b.blue;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		@(negedge clk);
		commands_sent++;
		dirty = 1'b1;
	endtask

	// register write once the block has gone quiet
	task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_DATA_W-1:0] val);
		cmd_bus.valid = 1'b0;
		if (dirty) begin
			while (pending_words.size() != 0) @(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
			dirty = 1'b0;
		end
		cfg_we    = 1'b1;
		cfg_index = sel;
		cfg_data  = val;
		apply_register(sel, val);
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	task automatic tick_once();
		send_command(cmd_row(ACT_TICK, $urandom_range(0, 255), $urandom_range(0, 511),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 1).beat,
			'0);
	endtask

	// one random setting: stores writes, a playback, and noise on the way
	task automatic run_phase();
		int unsigned roll;
		int unsigned led;
		int unsigned n;
		int unsigned ticks;
		logic [CFG_DATA_W-1:0] duty;
		roll = $urandom_range(0, 99);
		if (roll < 8) led = 0;
		else if (roll < 11) led = 255;
		else if (roll < 14) led = 256;
		else if (roll < 16) led = 511;
		else if (roll < 18) led = $urandom_range(9, 511);
		else led = $urandom_range(1, 4);
		write_register(REG_LED_COUNT, CFG_DATA_W'(led));
		for (int k = 0; k < 2; k++) begin
			roll = $urandom_range(0, 99);
			duty = (roll < 15) ? '0 : (roll < 30) ? 15'h7fff : CFG_DATA_W'($urandom_range(0, 32767));
			write_register((k == 0) ? REG_DUTY_ONE : REG_DUTY_ZERO, duty);
		end
		if ($urandom_range(0, 99) < 10)
			write_register(REG_SPARE, CFG_DATA_W'($urandom_range(0, 32767)));
		n = active_leds();
		repeat ($urandom_range(1, 5)) send_command(random_beat(n, 1'b0), '0);
		send_command(cmd_row(ACT_START, $urandom_range(0, 255), 0, 0, 0, 0, 1).beat, '0);
		if (n == 0) ticks = $urandom_range(2, 6);
		else if (n > 8) ticks = $urandom_range(20, 80);
		else ticks = n * 24 + 2;
		repeat (ticks) begin
			if ($urandom_range(0, 99) < 8) send_command(random_beat(n, 1'b1), '0);
			tick_once();
		end
		repeat ($urandom_range(0, 2)) tick_once();
	endtask

	// command side: predict on every accepted beat
	always @(posedge clk) begin : cmd_monitor
		beat_note_t note;
		bit         produced;
		word_beat_t res;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			note = (beat_notes.size() != 0) ? beat_notes.pop_front() : '0;
			apply_command('{cmd_bus.action, cmd_bus.index, cmd_bus.count, cmd_bus.red,
				cmd_bus.green, cmd_bus.blue}, produced, res);
			if (note.typed) begin
				if (note.typed_has) pending_words.push_back(note.typed_res);
			end else if (produced) begin
				pending_words.push_back(res);
			end
		end
	end

	// word side: compare each beat with the oldest expected word
	always @(posedge clk) begin : word_monitor
		word_beat_t want;
		if (arst_n && seq_bus.valid && seq_bus.ready) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected word beat: sequence_word %h last_word %b",
					seq_bus.sequence_word, seq_bus.last_word);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (seq_bus.sequence_word !== want.sequence_word) begin
					$error("sequence_word mismatch: expected %h, got %h",
						want.sequence_word, seq_bus.sequence_word);
					errors++;
				end
				if (seq_bus.last_word !== want.last_word) begin
					$error("last_word mismatch: expected %b, got %b",
						want.last_word, seq_bus.last_word);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (seq_bus.valid && seq_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles with no beat", stall_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off
	initial begin : word_sink
		bit held;
		held = 1'b0;
		seq_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_seen >= HOLD_AFTER) begin
				held = 1'b1;
				seq_bus.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			seq_bus.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// stimulus
	initial begin : stimulus
		int base;
		int phases;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = '0;
		cmd_bus.index = '0;
		cmd_bus.count = '0;
		cmd_bus.red = '0;
		cmd_bus.green = '0;
		cmd_bus.blue = '0;
		errors = 0;
		commands_sent = 0;
		words_seen = 0;
		reg_writes = 0;
		stall_cycles = 0;
		calm = 1'b0;
		dirty = 1'b0;
		phases = 0;
		foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
		playing = 1'b0;
		word_pos = '0;
		leds_reg = '0;
		duty_one_reg = DUTY_ONE_RST;
		duty_zero_reg = DUTY_ZERO_RST;

		// directed table
		plan.push_back(typed_row(ACT_START, 1'b0, '0, 1'b0));
		plan.push_back(typed_row(ACT_TICK, 1'b0, '0, 1'b0));
		plan.push_back(reg_row(REG_LED_COUNT, 1));
		plan.push_back(typed_row(ACT_TICK, 1'b0, '0, 1'b0));
		plan.push_back(typed_row(ACT_SPARE_LO, 1'b0, '0, 1'b0));
		plan.push_back(typed_row(ACT_SPARE_HI, 1'b0, '0, 1'b0));
		plan.push_back(cmd_row(ACT_START, 0, 0, 0, 0, 0, 1));
		plan.push_back(typed_row(ACT_TICK, 1'b1, {1'b0, DUTY_ZERO_RST}, 1'b0));
		plan.push_back(cmd_row(ACT_SET, 0, 0, 8'hff, 8'hff, 8'hff, 1));
		plan.push_back(typed_row(ACT_TICK, 1'b1, {1'b0, DUTY_ONE_RST}, 1'b0));
		plan.push_back(cmd_row(ACT_SET, 1, 0, 8'h11, 8'h22, 8'h33, 1));
		plan.push_back(cmd_row(ACT_SET, 255, 0, 8'h44, 8'h55, 8'h66, 1));
		plan.push_back(cmd_row(ACT_FILL, 0, 0, 8'h00, 8'h00, 8'h00, 1));
		plan.push_back(cmd_row(ACT_FILL, 0, 2, 8'h00, 8'h00, 8'h00, 1));
		plan.push_back(cmd_row(ACT_FILL, 0, 1, 8'h5a, 8'ha5, 8'h3c, 1));
		plan.push_back(cmd_row(ACT_START, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(ACT_TICK, 0, 0, 0, 0, 0, 24));
		plan.push_back(typed_row(ACT_TICK, 1'b1, PAD_WORD, 1'b0));
		plan.push_back(typed_row(ACT_TICK, 1'b1, PAD_WORD, 1'b1));
		plan.push_back(typed_row(ACT_TICK, 1'b0, '0, 1'b0));
		plan.push_back(reg_row(REG_DUTY_ONE, 15'h7fff));
		plan.push_back(reg_row(REG_DUTY_ZERO, 0));
		plan.push_back(reg_row(REG_LED_COUNT, 256));
		plan.push_back(cmd_row(ACT_FILL, 0, 256, 8'hc3, 8'h81, 8'h7e, 1));
		plan.push_back(cmd_row(ACT_FILL, 1, 256, 8'hff, 8'hff, 8'hff, 1));
		plan.push_back(cmd_row(ACT_SET, 255, 0, 8'hf0, 8'h0f, 8'haa, 1));
		plan.push_back(cmd_row(ACT_START, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(ACT_TICK, 0, 0, 0, 0, 0, 10));
		// count dropped below the position: straight to the last padding word
		plan.push_back(reg_row(REG_LED_COUNT, 0));
		plan.push_back(typed_row(ACT_TICK, 1'b1, PAD_WORD, 1'b1));
		plan.push_back(reg_row(REG_SPARE, 15'h7fff));
		plan.push_back(reg_row(REG_LED_COUNT, 511));
		plan.push_back(cmd_row(ACT_SET, 255, 0, 8'h01, 8'h80, 8'hfe, 1));
		plan.push_back(cmd_row(ACT_CLEAR, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(ACT_START, 0, 0, 0, 0, 0, 1));
		plan.push_back(cmd_row(ACT_TICK, 0, 0, 0, 0, 0, 4));

		// hold reset, then release it
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_register(plan[i].reg_sel, plan[i].reg_val);
			else
				repeat (plan[i].reps) send_command(plan[i].beat, plan[i].note);
		end

		// random settings until enough commands have gone in
		base = commands_sent;
		while (commands_sent - base < RANDOM_ITEMS) begin
			calm = (phases >= 4 && phases <= 6);
			run_phase();
			phases++;
		end
		calm = 1'b0;

		// drain
		cmd_bus.valid = 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d expected word beats never arrived", pending_words.size());
			errors++;
		end

		$display("covered %0d commands over %0d random settings and %0d register writes,",
			commands_sent, phases, reg_writes);
		$display("with %0d duty and padding words checked, %0d mismatches", words_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule : tb_top
